FILE: sv/bps_pkg.sv
// Shared types, constants and helpers for the byte pattern search block.
`timescale 1ns / 1ps
package bps_pkg;

    localparam int PATTERN_MAX_DEF = 16;
    localparam int OFFSET_BITS_DEF = 32;

    localparam int REG_BYTES    = 16;
    localparam int LEN_W        = 5;
    localparam int IDX_W        = $clog2(REG_BYTES);
    localparam int HIT_START_W  = 32;
    localparam int CFG_INDEX_W  = 3;
    localparam int CFG_DATA_W   = 64;

    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LOW    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_HIGH   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LENGTH = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_FOLD_CASE      = 3'd3;

    localparam logic [7:0] ASCII_LOWER_A = 8'h61;
    localparam logic [7:0] ASCII_LOWER_Z = 8'h7A;
    localparam logic [7:0] ASCII_CASE_OFFSET = 8'h20;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } bps_in_t;

    typedef struct packed {
        logic                   hit;
        logic [HIT_START_W-1:0] hit_start;
        logic                   stream_end;
    } bps_out_t;

    typedef struct packed {
        logic shift;
        logic clear;
        logic fold;
    } bps_cell_ctrl_t;

    function automatic logic [7:0] fold_byte(input logic [7:0] b, input logic en);
        logic [7:0] r;
        r = b;
        if (en && (b >= ASCII_LOWER_A) && (b <= ASCII_LOWER_Z))
        begin
            r = b - ASCII_CASE_OFFSET;
        end
        return r;
    endfunction

endpackage

FILE: sv/bps_cell.sv
// One window cell: holds a recent byte, passes it on, compares it with its pattern byte.
`timescale 1ns / 1ps
module bps_cell (
    input  logic                    clk,
    input  logic                    rst_n,
    input  bps_pkg::bps_cell_ctrl_t ctrl,
    input  logic [7:0]              byte_in,
    input  logic [7:0]              pattern_byte,
    input  logic                    active,
    output logic [7:0]              byte_out,
    output logic                    match
);
    import bps_pkg::*;

    logic [7:0] byte_reg;
    logic [7:0] byte_next;

    always_comb
    begin
        byte_next = byte_reg;
        if (ctrl.clear)
        begin
            byte_next = '0;
        end
        else if (ctrl.shift)
        begin
            byte_next = byte_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_reg <= '0;
        end
        else
        begin
            byte_reg <= byte_next;
        end
    end

    assign byte_out = byte_reg;
    assign match    = !active || (fold_byte(byte_reg, ctrl.fold) == pattern_byte);

endmodule

FILE: sv/bps_out_buf.sv
// Result register with a skid stage between the compare and the output channel.
`timescale 1ns / 1ps
module bps_out_buf (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  bps_pkg::bps_out_t in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output bps_pkg::bps_out_t out_data
);
    import bps_pkg::*;

    logic     out_valid_reg;
    logic     out_valid_next;
    bps_out_t out_data_reg;
    bps_out_t out_data_next;
    logic     skid_valid_reg;
    logic     skid_valid_next;
    bps_out_t skid_data_reg;
    bps_out_t skid_data_next;
    logic     out_free;

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = in_valid;
                out_data_next  = in_data;
            end
        end
        else if (in_valid)
        begin
            // hold the beat until the output drains
            skid_valid_next = 1'b1;
            skid_data_next  = in_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

FILE: sv/byte_pattern_search_top.sv
// Top level of the byte pattern search: config registers, cell row, position counter.
`timescale 1ns / 1ps
// Takes one file byte per clock while in_ready is high and gives one result beat
// per byte, registered in the output buffer; the whole window is compared at once
// by a row of PATTERN_MAX-1 cells plus the incoming byte; a stalled output is
// absorbed by a two-beat output buffer before input ready drops. Write the pattern,
// length and case fold only while no beat is in flight.
module byte_pattern_search_top #(
    parameter int PATTERN_MAX = bps_pkg::PATTERN_MAX_DEF,
    parameter int OFFSET_BITS = bps_pkg::OFFSET_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [bps_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [bps_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  bps_pkg::bps_in_t                   in_data,
    output logic                               out_valid,
    input  logic                               out_ready,
    output bps_pkg::bps_out_t                  out_data
);
    import bps_pkg::*;

    localparam int CELLS   = PATTERN_MAX - 1;
    localparam int LEN_CAP = (PATTERN_MAX < REG_BYTES) ? PATTERN_MAX : REG_BYTES;
    localparam int FILL_W  = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

    logic [CFG_DATA_W-1:0]  pattern_low_reg;
    logic [CFG_DATA_W-1:0]  pattern_high_reg;
    logic [LEN_W-1:0]       pattern_length_reg;
    logic                   fold_case_reg;

    logic [OFFSET_BITS-1:0] pos_reg;
    logic [OFFSET_BITS-1:0] pos_next;
    logic [FILL_W-1:0]      fill_reg;
    logic [FILL_W-1:0]      fill_next;

    logic [7:0]             pat_fold [REG_BYTES];
    logic [7:0]             cell_byte [CELLS+1];
    logic [PATTERN_MAX-1:0] match;

    logic [LEN_W-1:0]       eff_len;
    logic [IDX_W-1:0]       top;
    logic                   len_ok;
    logic                   fill_ok;
    logic                   hit;
    logic                   accept;
    logic [OFFSET_BITS-1:0] start_off;
    bps_cell_ctrl_t         cell_ctrl;
    bps_out_t               res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_low_reg    <= '0;
            pattern_high_reg   <= '0;
            pattern_length_reg <= LEN_W'(1);
            fold_case_reg      <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_PATTERN_LOW:    pattern_low_reg    <= cfg_data;
                CFG_PATTERN_HIGH:   pattern_high_reg   <= cfg_data;
                CFG_PATTERN_LENGTH: pattern_length_reg <= cfg_data[LEN_W-1:0];
                CFG_FOLD_CASE:      fold_case_reg      <= cfg_data[0];
                default:            ;
            endcase
        end
    end

    genvar i;
    generate
        for (i = 0; i < REG_BYTES; i++)
        begin : g_pat
            if (i < 8)
            begin : g_low
                assign pat_fold[i] = fold_byte(pattern_low_reg[(i % 8) * 8 +: 8], fold_case_reg);
            end
            else
            begin : g_high
                assign pat_fold[i] = fold_byte(pattern_high_reg[(i % 8) * 8 +: 8], fold_case_reg);
            end
        end
    endgenerate

    assign eff_len = (pattern_length_reg > LEN_W'(LEN_CAP)) ? LEN_W'(LEN_CAP)
                                                             : pattern_length_reg;
    assign len_ok  = (eff_len != '0);
    assign top     = IDX_W'(eff_len - LEN_W'(1));
    assign fill_ok = (int'(fill_reg) >= int'(top));

    assign accept          = in_valid && in_ready;
    assign cell_ctrl.shift = accept && !in_data.last_byte;
    assign cell_ctrl.clear = accept && in_data.last_byte;
    assign cell_ctrl.fold  = fold_case_reg;

    assign cell_byte[0] = in_data.data_byte;
    assign match[0]     = (fold_byte(in_data.data_byte, fold_case_reg) == pat_fold[top]);

    genvar k;
    generate
        for (k = 1; k <= CELLS; k++)
        begin : g_cell
            logic active;
            assign active = (int'(top) >= k);
            bps_cell u_cell (
                .clk          (clk),
                .rst_n        (rst_n),
                .ctrl         (cell_ctrl),
                .byte_in      (cell_byte[k-1]),
                .pattern_byte (pat_fold[IDX_W'(int'(top) - k)]),
                .active       (active),
                .byte_out     (cell_byte[k]),
                .match        (match[k])
            );
        end
    endgenerate

    assign hit       = len_ok && fill_ok && (&match);
    assign start_off = pos_reg - OFFSET_BITS'(top);

    assign res.hit        = hit;
    assign res.hit_start  = hit ? HIT_START_W'(start_off) : '0;
    assign res.stream_end = in_data.last_byte;

    always_comb
    begin
        pos_next  = pos_reg;
        fill_next = fill_reg;
        if (cell_ctrl.clear)
        begin
            pos_next  = '0;
            fill_next = '0;
        end
        else if (cell_ctrl.shift)
        begin
            pos_next = pos_reg + OFFSET_BITS'(1);
            if (int'(fill_reg) < CELLS)
            begin
                fill_next = fill_reg + FILL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            fill_reg <= '0;
        end
        else
        begin
            pos_reg  <= pos_next;
            fill_reg <= fill_next;
        end
    end

    bps_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .in_ready  (in_ready),
        .in_data   (res),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

FILE: sim/tb_byte_pattern_search_top.sv
// Self-checking testbench for byte_pattern_search_top: directed and random file scans.
`timescale 1ns / 1ps
module tb_byte_pattern_search_top;
    import bps_pkg::*;

    localparam int WINDOW_DEPTH = PATTERN_MAX_DEF - 1;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_PHASES = 14;
    localparam int PHASE_BYTES  = 128;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_write = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    bps_in_t                in_data = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    bps_out_t               out_data;

    byte_pattern_search_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    logic [63:0]      pat_low = '0;
    logic [63:0]      pat_high = '0;
    logic [LEN_W-1:0] pat_len = LEN_W'(1);
    logic             fold_on = 1'b0;
    logic [7:0]       window [WINDOW_DEPTH];
    logic [31:0]      position = '0;
    int unsigned      fill_cnt = 0;

    bps_in_t  file_bytes [$];
    bps_out_t awaited_matches [$];

    int stall_pct = 0;
    int in_gap = 0;
    int out_gap = 0;
    int mismatches = 0;
    int bytes_sent = 0;
    int files_sent = 0;
    int hits_seen = 0;
    int settings_used = 0;
    int cycles = 0;

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, awaited_matches.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic logic [7:0] upcase(input logic [7:0] b);
        if (fold_on && b >= ASCII_LOWER_A && b <= ASCII_LOWER_Z)
        begin
            return b - ASCII_CASE_OFFSET;
        end
        return b;
    endfunction

    function automatic logic [7:0] pattern_at(input int unsigned i);
        if (i < 8)
        begin
            return pat_low[i*8 +: 8];
        end
        return pat_high[(i-8)*8 +: 8];
    endfunction

    function automatic int unsigned span();
        return (pat_len > PATTERN_MAX_DEF) ? PATTERN_MAX_DEF : pat_len;
    endfunction

    function automatic bps_out_t predict_match(input bps_in_t beat);
        bps_out_t    r;
        int unsigned n;
        logic        found;
        r = '0;
        r.stream_end = beat.last_byte;
        n = span();
        if (n >= 1 && fill_cnt >= n - 1)
        begin
            found = upcase(beat.data_byte) == upcase(pattern_at(n - 1));
            for (int k = 1; k < n; k++)
            begin
                if (upcase(window[k-1]) != upcase(pattern_at(n - 1 - k)))
                begin
                    found = 1'b0;
                end
            end
            if (found)
            begin
                r.hit = 1'b1;
                r.hit_start = position - (n - 1);
            end
        end
        if (beat.last_byte)
        begin
            window = '{default: '0};
            position = '0;
            fill_cnt = 0;
        end
        else
        begin
            for (int k = WINDOW_DEPTH - 1; k > 0; k--)
            begin
                window[k] = window[k-1];
            end
            window[0] = beat.data_byte;
            if (fill_cnt < WINDOW_DEPTH)
            begin
                fill_cnt++;
            end
            position = position + 1;
        end
        return r;
    endfunction

    task automatic check_beat(input bps_out_t got);
        bps_out_t want;
        if (awaited_matches.size() == 0)
        begin
            if (mismatches < 10)
            begin
                $display("unexpected beat: hit %0b start %0d end %0b",
                         got.hit, got.hit_start, got.stream_end);
            end
            mismatches++;
        end
        else
        begin
            want = awaited_matches.pop_front();
            if (got.hit !== want.hit || got.hit_start !== want.hit_start
                || got.stream_end !== want.stream_end)
            begin
                if (mismatches < 10)
                begin
                    $display({"mismatch: expected hit %0b start %0d end %0b,",
                              " got hit %0b start %0d end %0b"},
                             want.hit, want.hit_start, want.stream_end,
                             got.hit, got.hit_start, got.stream_end);
                end
                mismatches++;
            end
            else if (got.hit)
            begin
                hits_seen++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_gap <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                awaited_matches.push_back(predict_match(in_data));
                bytes_sent++;
            end
            if (in_valid && !in_ready)
            begin
                // hold the beat until taken
            end
            else if (in_gap > 0)
            begin
                in_valid <= 1'b0;
                in_gap <= in_gap - 1;
            end
            else if (file_bytes.size() != 0 && $urandom_range(99) < stall_pct)
            begin
                in_valid <= 1'b0;
                in_gap <= $urandom_range(7);
            end
            else if (file_bytes.size() != 0)
            begin
                in_valid <= 1'b1;
                in_data <= file_bytes.pop_front();
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            out_gap <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                check_beat(out_data);
            end
            if (out_gap > 0)
            begin
                out_ready <= 1'b0;
                out_gap <= out_gap - 1;
            end
            else if ($urandom_range(99) < stall_pct)
            begin
                out_ready <= 1'b0;
                out_gap <= $urandom_range(7);
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [63:0] val);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            CFG_PATTERN_LOW:    pat_low = val;
            CFG_PATTERN_HIGH:   pat_high = val;
            CFG_PATTERN_LENGTH: pat_len = val[LEN_W-1:0];
            CFG_FOLD_CASE:      fold_on = val[0];
            default: ;
        endcase
    endtask

    task automatic configure(input logic [63:0] low, input logic [63:0] high,
                             input logic [63:0] len_word, input logic [63:0] fold_word);
        write_reg(CFG_FOLD_CASE + CFG_INDEX_W'(1) + CFG_INDEX_W'($urandom_range(3)),
                  {$urandom, $urandom});
        write_reg(CFG_PATTERN_LOW, low);
        write_reg(CFG_PATTERN_HIGH, high);
        write_reg(CFG_PATTERN_LENGTH, len_word);
        write_reg(CFG_FOLD_CASE, fold_word);
        @(posedge clk);
        cfg_write <= 1'b0;
        @(negedge clk);
        settings_used++;
    endtask

    task automatic settle();
        do
            @(posedge clk);
        while (file_bytes.size() != 0 || in_valid || awaited_matches.size() != 0);
    endtask

    task automatic queue_byte(input logic [7:0] b, input logic last);
        bps_in_t beat;
        beat.data_byte = b;
        beat.last_byte = last;
        file_bytes.push_back(beat);
        if (last)
        begin
            files_sent++;
        end
    endtask

    task automatic add_file(input int nbytes, input int plant_pct);
        int          k;
        int unsigned n;
        logic [7:0]  b;
        n = span();
        k = -1;
        for (int i = 0; i < nbytes; i++)
        begin
            if (k < 0 && n > 0 && $urandom_range(99) < plant_pct)
            begin
                k = 0;
            end
            if (k >= 0)
            begin
                b = pattern_at(k);
                k++;
                if (k == n)
                begin
                    k = -1;
                end
            end
            else if (n == 0 || $urandom_range(3) == 0)
            begin
                b = 8'($urandom);
            end
            else
            begin
                b = pattern_at($urandom_range(n - 1));
            end
            if (((b | ASCII_CASE_OFFSET) >= ASCII_LOWER_A)
                && ((b | ASCII_CASE_OFFSET) <= ASCII_LOWER_Z) && $urandom_range(7) == 0)
            begin
                b = b ^ ASCII_CASE_OFFSET;
            end
            queue_byte(b, i == nbytes - 1);
        end
    endtask

    initial
    begin
        logic [127:0] pat;
        logic [7:0]   b;
        int           len;
        int           r;
        int           queued;
        window = '{default: '0};
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: single zero byte pattern
        queue_byte(8'h00, 1'b0);
        queue_byte(8'hFF, 1'b1);
        settle();

        configure(64'h0000_0000_0063_4261, 64'h0, 64'd3, 64'd1);
        queue_byte("a", 1'b0);
        queue_byte("b", 1'b1);
        queue_byte("c", 1'b0);
        queue_byte("A", 1'b0);
        queue_byte("b", 1'b0);
        queue_byte("C", 1'b0);
        queue_byte(8'h60, 1'b0);
        queue_byte(8'h7B, 1'b0);
        queue_byte("z", 1'b1);
        settle();

        configure(64'h0000_0000_0063_4261, 64'h0, 64'd0, 64'd0);
        queue_byte("a", 1'b0);
        queue_byte("B", 1'b0);
        queue_byte("c", 1'b1);
        settle();

        configure(64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 64'd31, 64'd0);
        for (int i = 0; i < REG_BYTES; i++)
        begin
            queue_byte(pattern_at(i), i == REG_BYTES - 1);
        end
        settle();

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            for (int j = 0; j < REG_BYTES; j++)
            begin
                if ($urandom_range(1))
                begin
                    b = 8'($urandom_range(ASCII_LOWER_A, ASCII_LOWER_Z));
                    b = $urandom_range(1) ? b ^ ASCII_CASE_OFFSET : b;
                end
                else
                begin
                    b = 8'($urandom);
                end
                pat[j*8 +: 8] = b;
            end
            if (p == 4)
            begin
                pat = '1;
            end
            else if (p == 5)
            begin
                pat = '0;
            end
            r = $urandom_range(9);
            case (p)
                0: len = 1;
                1: len = 16;
                2: len = 31;
                3: len = 0;
                default: len = (r < 6) ? $urandom_range(1, 6)
                             : (r < 9) ? $urandom_range(7, 16) : $urandom_range(17, 31);
            endcase
            r = $urandom_range(2);
            stall_pct = (p >= RANDOM_PHASES - 2) ? 0 : (r == 0) ? 0 : (r == 1) ? 10 : 35;
            configure(pat[63:0], pat[127:64],
                      ({$urandom, $urandom} & ~64'h1F) | 64'(len),
                      (p == 0) ? 64'd1 : (p == 1) ? 64'd0 : {$urandom, $urandom});
            queued = 0;
            while (queued < PHASE_BYTES)
            begin
                r = $urandom_range(1, 2 * span() + 12);
                add_file(r, 25);
                queued += r;
            end
            settle();
        end

        repeat (8) @(posedge clk);
        $display("scanned %0d bytes in %0d files under %0d pattern settings",
                 bytes_sent, files_sent, settings_used);
        $display("%0d hits confirmed, %0d mismatches", hits_seen, mismatches);
        if (mismatches == 0 && awaited_matches.size() == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

FILE: byte_pattern_search_top.f
sv/bps_pkg.sv
sv/bps_cell.sv
sv/bps_out_buf.sv
sv/byte_pattern_search_top.sv
sim/tb_byte_pattern_search_top.sv
